// ===== design/cut_vertex_component_ranker_assert.svh =====
// Assertion macros used by the cut vertex ranker back end
`ifndef CUT_VERTEX_COMPONENT_RANKER_ASSERT_SVH
`define CUT_VERTEX_COMPONENT_RANKER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CVR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cut vertex ranker check failed");
// next-cycle implication
`define CVR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cut vertex ranker check failed");
`else
`define CVR_ASSERT_IMP(lbl, ante, cons)
`define CVR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/cvr_pkg.sv =====
// Types and constants of the cut vertex ranker
package cvr_pkg;
   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = NODE_W + 1;
   localparam int EADDR_W   = $clog2(MAX_EDGES);
   localparam int ETOT_W    = EADDR_W + 1;
   localparam int HALF_W    = ETOT_W + 1;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);

   localparam logic CSR_NODE_COUNT   = 1'b0;
   localparam logic CSR_REPORT_COUNT = 1'b1;

   typedef struct packed {
      logic [5:0] end_a;
      logic [5:0] end_b;
      logic       has_edge;
      logic       last_edge;
   } req_type;

   typedef struct packed {
      logic [5:0] node;
      logic [6:0] piece_count;
      logic       last_result;
      logic       edges_dropped;
   } rsp_type;

   // clamped configuration in force
   typedef struct packed {
      logic [CNT_W-1:0] node_count;
      logic [CNT_W-1:0] report_count;
   } cfg_type;

   // classified item in the queue
   typedef struct packed {
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
      logic              store;
      logic              drop;
      logic              last;
   } qent_type;

   typedef struct packed {
      logic run_done;
   } back_stat_type;

   // walk frame
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] parent;
      logic [HALF_W-1:0] half;
      logic [NODE_W-1:0] num;
      logic [NODE_W-1:0] low;
      logic [NODE_W-1:0] cut;
   } frame_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_PRE_RD, ST_PRE_EV, ST_ROOT, ST_SCAN, ST_EVAL, ST_BACK,
      ST_POP, ST_POP2, ST_RANK, ST_EMIT, ST_CLEAR
   } back_state_type;
endpackage

// ===== design/cvr_front.sv =====
// Front end: accepts items, range-checks edges, tracks a pending run
module cvr_front import cvr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   input  cfg_type       cfg,
   input  logic          q_full,
   input  back_stat_type stat,
   output logic          push,
   output qent_type      entry
);
   logic pend_ff, pend_in;
   logic in_rng;

   // hold off new items while the queue is full or a run is in progress
   assign busy = pend_ff | q_full;
   assign push = start & ~busy;

   // classify the edge
   assign in_rng = ({1'b0, req_data.end_a} < cfg.node_count) &&
                   ({1'b0, req_data.end_b} < cfg.node_count);
   assign entry.a     = req_data.end_a;
   assign entry.b     = req_data.end_b;
   assign entry.store = req_data.has_edge & in_rng;
   assign entry.drop  = req_data.has_edge & ~in_rng;
   assign entry.last  = req_data.last_edge;

   always_comb begin
      pend_in = pend_ff;
      if (push && req_data.last_edge) begin
         pend_in = 1'b1;
      end else if (stat.run_done) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end
endmodule

// ===== design/cvr_queue.sv =====
// Short queue between front and back end
module cvr_queue import cvr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  qent_type din,
   input  logic     pop,
   output qent_type dout,
   output logic     empty,
   output logic     full
);
   qent_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign dout  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= din;
      end
   end
endmodule

// ===== design/cvr_back.sv =====
// Back end: edge store, depth-first walk, ranking and result strobes
`include "cut_vertex_component_ranker_assert.svh"
module cvr_back import cvr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          q_empty,
   input  qent_type      q_data,
   output logic          q_pop,
   output back_stat_type stat,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);
   back_state_type state_ff, state_in;
   logic [ETOT_W-1:0]    etot_ff, etot_in, pre_ff, pre_in;
   logic                 drop_ff, drop_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in, taken_ff, taken_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, root_ff, root_in, depth_ff, depth_in;
   logic [CNT_W-1:0]     rk_i_ff, rk_i_in, k_ff, k_in;
   logic [NODE_W-1:0]    kids_ff, kids_in;
   frame_type            top_ff, top_in;
   logic                 rk_vld_ff, rk_vld_in, have_ff, have_in;
   logic [NODE_W-1:0]    rk_idx_ff, rk_idx_in, best_ff, best_in, best_sc_ff, best_sc_in;

   // memories
   logic [2*NODE_W-1:0] edge_mem [MAX_EDGES];
   logic [2*NODE_W-1:0] edge_rd_ff, edge_wd;
   logic [EADDR_W-1:0]  edge_wa, edge_ra;
   logic                edge_we;
   frame_type           stack_mem [MAX_NODES];
   frame_type           stack_rd_ff, stack_wd;
   logic [NODE_W-1:0]   stack_wa, stack_ra;
   logic                stack_we;
   logic [NODE_W-1:0]   vn_mem [MAX_NODES];
   logic [NODE_W-1:0]   vn_rd_ff, vn_wd, vn_wa, vn_ra;
   logic                vn_we;
   logic [NODE_W-1:0]   cut_mem [MAX_NODES];
   logic [NODE_W-1:0]   cut_rd_ff, cut_wd, cut_wa, cut_ra;
   logic                cut_we;

   logic [NODE_W-1:0]   ea, eb, src, dst, rnode;
   logic [HALF_W-1:0]   halves;
   logic                e_bad, qual;
   frame_type           wf, nf;
   logic                rk_last;

   assign ea     = edge_rd_ff[2*NODE_W-1:NODE_W];
   assign eb     = edge_rd_ff[NODE_W-1:0];
   assign e_bad  = ({1'b0, ea} >= cfg.node_count) || ({1'b0, eb} >= cfg.node_count);
   assign src    = top_ff.half[0] ? eb : ea;
   assign dst    = top_ff.half[0] ? ea : eb;
   assign halves = {etot_ff, 1'b0};
   assign rnode  = root_ff[NODE_W-1:0];
   assign wf     = stack_rd_ff;
   assign qual   = top_ff.low >= wf.num;
   assign rk_last = (k_ff + 1'b1) == cfg.report_count;

   always_comb begin
      state_in   = state_ff;
      etot_in    = etot_ff;
      pre_in     = pre_ff;
      drop_in    = drop_ff;
      visited_in = visited_ff;
      taken_in   = taken_ff;
      cnt_in     = cnt_ff;
      root_in    = root_ff;
      depth_in   = depth_ff;
      rk_i_in    = rk_i_ff;
      k_in       = k_ff;
      kids_in    = kids_ff;
      top_in     = top_ff;
      rk_vld_in  = 1'b0;
      rk_idx_in  = rk_idx_ff;
      have_in    = have_ff;
      best_in    = best_ff;
      best_sc_in = best_sc_ff;
      nf         = wf;
      q_pop      = 1'b0;
      stat       = '0;
      rsp_valid  = 1'b0;
      rsp_data   = '0;
      edge_we = 1'b0; edge_wa = etot_ff[EADDR_W-1:0]; edge_wd = {q_data.a, q_data.b};
      edge_ra = pre_ff[EADDR_W-1:0];
      stack_we = 1'b0; stack_wa = depth_ff[NODE_W-1:0]; stack_wd = top_ff;
      stack_ra = depth_ff[NODE_W-1:0] - 1'b1;
      vn_we = 1'b0; vn_wa = rnode; vn_wd = cnt_ff[NODE_W-1:0]; vn_ra = dst;
      cut_we = 1'b0; cut_wa = top_ff.node; cut_wd = top_ff.cut;
      cut_ra = rk_i_ff[NODE_W-1:0];
      case (state_ff)
         // store classified edges until the last item
         ST_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_data.store) begin
                  if (etot_ff == ETOT_W'(MAX_EDGES)) begin
                     drop_in = 1'b1;
                  end else begin
                     edge_we = 1'b1;
                     etot_in = etot_ff + 1'b1;
                  end
               end
               if (q_data.drop) begin
                  drop_in = 1'b1;
               end
               if (q_data.last) begin
                  pre_in   = '0;
                  state_in = ST_PRE_RD;
               end
            end
         end
         // recheck stored edges against the node count now in force
         ST_PRE_RD: begin
            if (pre_ff == etot_ff) begin
               root_in  = '0;
               state_in = ST_ROOT;
            end else begin
               state_in = ST_PRE_EV;
            end
         end
         ST_PRE_EV: begin
            if (e_bad) begin
               drop_in = 1'b1;
            end
            pre_in   = pre_ff + 1'b1;
            state_in = ST_PRE_RD;
         end
         // next unvisited root
         ST_ROOT: begin
            if (root_ff == cfg.node_count) begin
               k_in     = '0;
               taken_in = '0;
               rk_i_in  = '0;
               have_in  = 1'b0;
               state_in = ST_RANK;
            end else if (visited_ff[rnode]) begin
               root_in = root_ff + 1'b1;
            end else begin
               visited_in[rnode] = 1'b1;
               vn_we    = 1'b1;
               top_in   = '{node: rnode, parent: rnode, half: '0,
                            num: cnt_ff[NODE_W-1:0], low: cnt_ff[NODE_W-1:0], cut: '0};
               cnt_in   = cnt_ff + 1'b1;
               depth_in = '0;
               kids_in  = '0;
               state_in = ST_SCAN;
            end
         end
         // fetch the next half edge of the top node
         ST_SCAN: begin
            edge_ra = top_ff.half[EADDR_W:1];
            if (top_ff.half == halves) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            top_in.half = top_ff.half + 1'b1;
            state_in    = ST_SCAN;
            if (!e_bad && src == top_ff.node) begin
               if (!visited_ff[dst]) begin
                  // descend: save the current frame, dst becomes top
                  visited_in[dst] = 1'b1;
                  vn_we         = 1'b1;
                  vn_wa         = dst;
                  stack_we      = 1'b1;
                  stack_wd.half = top_ff.half + 1'b1;
                  depth_in      = depth_ff + 1'b1;
                  top_in = '{node: dst, parent: top_ff.node, half: '0,
                             num: cnt_ff[NODE_W-1:0], low: cnt_ff[NODE_W-1:0], cut: '0};
                  cnt_in = cnt_ff + 1'b1;
               end else if (dst != top_ff.parent) begin
                  state_in = ST_BACK;
               end
            end
         end
         // back edge: fold in the neighbor's number
         ST_BACK: begin
            if (vn_rd_ff < top_ff.low) begin
               top_in.low = vn_rd_ff;
            end
            state_in = ST_SCAN;
         end
         // top node finished: record its score
         ST_POP: begin
            cut_we = 1'b1;
            if (depth_ff == '0) begin
               root_in  = root_ff + 1'b1;
               state_in = ST_ROOT;
            end else begin
               state_in = ST_POP2;
            end
         end
         ST_POP2: begin
            depth_in = depth_ff - 1'b1;
            if (wf.parent == wf.node) begin
               kids_in = kids_ff + 1'b1;
               if (qual) begin
                  nf.cut = kids_ff;
               end
            end else if (qual) begin
               nf.cut = wf.cut + 1'b1;
            end
            if (top_ff.low < wf.low) begin
               nf.low = top_ff.low;
            end
            top_in   = nf;
            state_in = ST_SCAN;
         end
         // find the best untaken node, lower index wins ties
         ST_RANK: begin
            if (rk_i_ff != cfg.node_count) begin
               rk_vld_in = 1'b1;
               rk_idx_in = rk_i_ff[NODE_W-1:0];
               rk_i_in   = rk_i_ff + 1'b1;
            end
            if (rk_vld_ff) begin
               if (!taken_ff[rk_idx_ff] && (!have_ff || cut_rd_ff > best_sc_ff)) begin
                  best_in    = rk_idx_ff;
                  best_sc_in = cut_rd_ff;
                  have_in    = 1'b1;
               end
            end else if (rk_i_ff == cfg.node_count) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid              = 1'b1;
            rsp_data.node          = best_ff;
            rsp_data.piece_count   = {1'b0, best_sc_ff} + 1'b1;
            rsp_data.last_result   = rk_last;
            rsp_data.edges_dropped = drop_ff;
            taken_in[best_ff] = 1'b1;
            k_in    = k_ff + 1'b1;
            rk_i_in = '0;
            have_in = 1'b0;
            state_in = rk_last ? ST_CLEAR : ST_RANK;
         end
         // drop the graph for the next run
         ST_CLEAR: begin
            etot_in       = '0;
            drop_in       = 1'b0;
            visited_in    = '0;
            cnt_in        = '0;
            stat.run_done = 1'b1;
            state_in      = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         etot_ff    <= '0;
         drop_ff    <= 1'b0;
         visited_ff <= '0;
         cnt_ff     <= '0;
         rk_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         etot_ff    <= etot_in;
         drop_ff    <= drop_in;
         visited_ff <= visited_in;
         cnt_ff     <= cnt_in;
         rk_vld_ff  <= rk_vld_in;
      end
   end

   // walk and ranking working registers
   always_ff @(posedge clock) begin
      pre_ff     <= pre_in;
      taken_ff   <= taken_in;
      root_ff    <= root_in;
      depth_ff   <= depth_in;
      rk_i_ff    <= rk_i_in;
      k_ff       <= k_in;
      kids_ff    <= kids_in;
      top_ff     <= top_in;
      rk_idx_ff  <= rk_idx_in;
      have_ff    <= have_in;
      best_ff    <= best_in;
      best_sc_ff <= best_sc_in;
   end

   // memory ports: one write, one registered read each
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      edge_rd_ff <= edge_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      stack_rd_ff <= stack_mem[stack_ra];
   end

   always_ff @(posedge clock) begin
      if (vn_we) begin
         vn_mem[vn_wa] <= vn_wd;
      end
      vn_rd_ff <= vn_mem[vn_ra];
   end

   always_ff @(posedge clock) begin
      if (cut_we) begin
         cut_mem[cut_wa] <= cut_wd;
      end
      cut_rd_ff <= cut_mem[cut_ra];
   end

   `CVR_ASSERT_NXT(a_last_clears, rsp_valid && rsp_data.last_result, state_ff == ST_CLEAR)
   `CVR_ASSERT_IMP(a_no_repeat, rsp_valid, !taken_ff[best_ff])
   `CVR_ASSERT_IMP(a_load_clean, state_ff == ST_LOAD, visited_ff == '0 && cnt_ff == '0)
endmodule

// ===== design/cut_vertex_component_ranker.sv =====
// Top level of the cut vertex ranker: config registers, front, queue, back
//
// channel  | handshake                  | payload
// req      | start, busy (out)          | req_data   (end_a, end_b, has_edge, last_edge)
// rsp      | rsp_valid strobe           | rsp_data   (node, piece_count, last_result,
//          |                            |             edges_dropped)
// csr      | csr_valid, csr_ready       | csr_index, csr_wdata
//
// Edge items transfer one per cycle, while busy is low, into a 4-entry queue and are
// stored as the back end drains them. A last item raises busy until the run ends: a
// range pass over the stored edges, the walk (a scan of the half edges of each node,
// a fold for each back edge, a finish for each node, a try for each root), then
// report_count ranking passes, each followed by a one-cycle result strobe, and a
// clear of the graph. Results cannot be held off.
// Reset is synchronous; node_count resets to 64 and report_count to 1.
module cut_vertex_component_ranker import cvr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);
   logic [6:0]    node_count_ff, report_count_ff;
   cfg_type       cfg;
   logic          push, pop, q_empty, q_full;
   qent_type      q_in, q_out;
   back_stat_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff   <= 7'(MAX_NODES);
         report_count_ff <= 7'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NODE_COUNT:   node_count_ff   <= csr_wdata;
            CSR_REPORT_COUNT: report_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the counts into their legal ranges
   always_comb begin
      if (node_count_ff == '0) begin
         cfg.node_count = CNT_W'(1);
      end else if (node_count_ff > 7'(MAX_NODES)) begin
         cfg.node_count = CNT_W'(MAX_NODES);
      end else begin
         cfg.node_count = CNT_W'(node_count_ff);
      end
      if (report_count_ff == '0) begin
         cfg.report_count = CNT_W'(1);
      end else if (CNT_W'(report_count_ff) > cfg.node_count) begin
         cfg.report_count = cfg.node_count;
      end else begin
         cfg.report_count = CNT_W'(report_count_ff);
      end
   end

   cvr_front u_front (
      .clock, .reset, .start, .busy, .req_data, .cfg,
      .q_full, .stat, .push, .entry(q_in)
   );

   cvr_queue u_queue (
      .clock, .reset, .push, .din(q_in), .pop, .dout(q_out),
      .empty(q_empty), .full(q_full)
   );

   cvr_back u_back (
      .clock, .reset, .cfg, .q_empty, .q_data(q_out), .q_pop(pop),
      .stat, .rsp_valid, .rsp_data
   );
endmodule

// ===== tb/sv/tb_cut_vertex_component_ranker.sv =====
// Self-checking testbench of the cut vertex component ranker
`timescale 1ns / 100ps

module tb_cut_vertex_component_ranker;
   import cvr_pkg::*;

   localparam int WATCHDOG_LIMIT = 500000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int RANDOM_ITEMS   = 170;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      item;
      logic         index;
      logic [6:0]   wdata;
      bit           known;
      rsp_type      known_rsp;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_index;
   logic [6:0] csr_wdata;

   cut_vertex_component_ranker uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the ranker state
   int unsigned node_limit;
   int unsigned report_limit;
   int unsigned edge_a [MAX_EDGES];
   int unsigned edge_b [MAX_EDGES];
   int unsigned edge_total;
   bit          drop_seen;
   bit          seen [MAX_NODES];
   int unsigned disc_num [MAX_NODES];
   int unsigned low_num [MAX_NODES];
   int unsigned cut_score [MAX_NODES];
   int unsigned kids [MAX_NODES];
   int unsigned stk_node [MAX_NODES];
   int unsigned stk_parent [MAX_NODES];
   int unsigned stk_half [MAX_NODES];
   int unsigned disc_count;

   rsp_type ranked_q [$];
   int      mismatches = 0;
   int      table_errors;
   int      items_sent;
   int      runs_done;
   int      results_seen = 0;
   bit      idling_on;
   int      idle_cycles = 0;

   function automatic void clear_graph();
      edge_total = 0;
      drop_seen  = 1'b0;
      disc_count = 0;
      for (int i = 0; i < MAX_NODES; i++) begin
         seen[i] = 1'b0;
         disc_num[i] = 0;
         low_num[i] = 0;
         cut_score[i] = 0;
         kids[i] = 0;
      end
   endfunction

   function automatic void mark_visit(int unsigned u);
      seen[u]     = 1'b1;
      disc_num[u] = disc_count;
      low_num[u]  = disc_count;
      disc_count++;
   endfunction

   // Tarjan walk over all components with an explicit frame stack
   function automatic void cut_walk(int unsigned n);
      int unsigned halves, sp, h, e, a, b, src, dst, u, w, top;
      bit found;
      halves = edge_total * 2;
      for (h = 0; h < halves; h++) begin
         e = h >> 1;
         if (edge_a[e] >= n || edge_b[e] >= n) drop_seen = 1'b1;
      end
      for (int unsigned r = 0; r < n; r++) begin
         if (seen[r]) continue;
         mark_visit(r);
         stk_node[0] = r;
         stk_parent[0] = r;
         stk_half[0] = 0;
         sp = 1;
         while (sp > 0) begin
            top = sp - 1;
            u = stk_node[top];
            found = 1'b0;
            for (h = stk_half[top]; h < halves; h++) begin
               e = h >> 1;
               a = edge_a[e];
               b = edge_b[e];
               src = h[0] ? b : a;
               dst = h[0] ? a : b;
               if (a >= n || b >= n || src != u) continue;
               stk_half[top] = h + 1;
               found = 1'b1;
               if (!seen[dst]) begin
                  mark_visit(dst);
                  if (sp < MAX_NODES) begin
                     stk_node[sp] = dst;
                     stk_parent[sp] = u;
                     stk_half[sp] = 0;
                     sp++;
                  end
               end else if (dst != stk_parent[top]) begin
                  if (disc_num[dst] < low_num[u]) low_num[u] = disc_num[dst];
               end
               break;
            end
            if (found) continue;
            sp--;
            if (sp > 0) begin
               w = stk_node[sp - 1];
               kids[w]++;
               if (low_num[u] >= disc_num[w]) begin
                  if (stk_parent[sp - 1] == w) cut_score[w] = kids[w] - 1;
                  else cut_score[w] = cut_score[w] + 1;
               end
               if (low_num[u] < low_num[w]) low_num[w] = low_num[u];
            end
         end
      end
   endfunction

   // load one item; on the last item walk, rank and queue the ranked nodes
   function automatic void predict_ranking(req_type it);
      int unsigned n, rc, best;
      bit have;
      bit taken [MAX_NODES];
      rsp_type r;
      n = (node_limit == 0) ? 1 : (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
      if (it.has_edge) begin
         if (it.end_a >= n || it.end_b >= n || edge_total >= MAX_EDGES) begin
            drop_seen = 1'b1;
         end else begin
            edge_a[edge_total] = it.end_a;
            edge_b[edge_total] = it.end_b;
            edge_total++;
         end
      end
      if (!it.last_edge) return;
      cut_walk(n);
      rc = (report_limit == 0) ? 1 : (report_limit > n) ? n : report_limit;
      for (int i = 0; i < MAX_NODES; i++) taken[i] = 1'b0;
      for (int unsigned k = 0; k < rc; k++) begin
         best = 0;
         have = 1'b0;
         for (int unsigned i = 0; i < n; i++) begin
            if (taken[i]) continue;
            if (!have || cut_score[i] > cut_score[best]) begin
               best = i;
               have = 1'b1;
            end
         end
         taken[best] = 1'b1;
         r.node = best[5:0];
         r.piece_count = 7'(cut_score[best] + 1);
         r.last_result = (k + 1 == rc);
         r.edges_dropped = drop_seen;
         ranked_q = {ranked_q, r};
      end
      clear_graph();
   endfunction

   // one item transfer, with an optional random gap ahead of it
   task automatic send_item(req_type it);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      predict_ranking(it);
      items_sent++;
      if (it.last_edge) runs_done++;
   endtask

   // let queued edges and any run finish before touching registers
   task automatic wait_idle();
      start <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (ranked_q.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [6:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_NODE_COUNT) node_limit = val;
      else report_limit = val;
      csr_valid <= 1'b0;
   endtask

   function automatic req_type mk_item(int a, int b, int he, int le);
      req_type it;
      it.end_a = a[5:0];
      it.end_b = b[5:0];
      it.has_edge = he[0];
      it.last_edge = le[0];
      return it;
   endfunction

   function automatic rsp_type mk_rsp(int nd, int pc, int lr, int ed);
      rsp_type r;
      r.node = nd[5:0];
      r.piece_count = pc[6:0];
      r.last_result = lr[0];
      r.edges_dropped = ed[0];
      return r;
   endfunction

   // table rows: plain item, item with a typed-in first result, register write
   function automatic stim_row_type item_row(req_type it);
      stim_row_type rw;
      rw.kind = ROW_ITEM;
      rw.item = it;
      rw.index = CSR_NODE_COUNT;
      rw.wdata = '0;
      rw.known = 1'b0;
      rw.known_rsp = '0;
      return rw;
   endfunction

   function automatic stim_row_type known_row(req_type it, rsp_type rs);
      stim_row_type rw;
      rw = item_row(it);
      rw.known = 1'b1;
      rw.known_rsp = rs;
      return rw;
   endfunction

   function automatic stim_row_type csr_row(logic idx, logic [6:0] val);
      stim_row_type rw;
      rw = item_row('0);
      rw.kind = ROW_CSR;
      rw.index = idx;
      rw.wdata = val;
      return rw;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (ranked_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: node %0d pieces %0d",
               rsp_data.node, rsp_data.piece_count);
         end else begin
            if (rsp_data.node !== ranked_q[0].node ||
                rsp_data.piece_count !== ranked_q[0].piece_count ||
                rsp_data.last_result !== ranked_q[0].last_result ||
                rsp_data.edges_dropped !== ranked_q[0].edges_dropped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp node %0d pc %0d last %0d drop %0d, %s",
                     ranked_q[0].node, ranked_q[0].piece_count, ranked_q[0].last_result,
                     ranked_q[0].edges_dropped,
                     $sformatf("got %0d %0d %0d %0d", rsp_data.node,
                        rsp_data.piece_count, rsp_data.last_result,
                        rsp_data.edges_dropped));
            end
            void'(ranked_q.pop_front());
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", ranked_q.size());
            $display("tb_cut_vertex_component_ranker: FAIL");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      int unsigned n, qpos, n_edges, sent_at_start;
      int a, b;
      req_type it;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_NODE_COUNT;
      csr_wdata = '0;
      table_errors = 0;
      items_sent = 0;
      runs_done = 0;
      idling_on = 1'b1;
      node_limit = 64;
      report_limit = 1;
      clear_graph();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      rows = {rows, known_row(mk_item(0, 0, 0, 1), mk_rsp(0, 1, 1, 0))};
      rows = {rows, csr_row(CSR_NODE_COUNT, 7'd5)};
      rows = {rows, csr_row(CSR_REPORT_COUNT, 7'd5)};
      // path graph: inner nodes are cut vertices
      rows = {rows, item_row(mk_item(0, 1, 1, 0))};
      rows = {rows, item_row(mk_item(1, 2, 1, 0))};
      rows = {rows, item_row(mk_item(2, 3, 1, 0))};
      rows = {rows, item_row(mk_item(3, 4, 1, 1))};
      // self-loop and parallel edges
      rows = {rows, item_row(mk_item(0, 0, 1, 0))};
      rows = {rows, item_row(mk_item(0, 1, 1, 0))};
      rows = {rows, item_row(mk_item(1, 0, 1, 0))};
      rows = {rows, item_row(mk_item(9, 9, 0, 1))};
      // out of range endpoint is dropped
      rows = {rows, item_row(mk_item(7, 1, 1, 0))};
      rows = {rows, known_row(mk_item(0, 1, 1, 1), mk_rsp(0, 1, 0, 1))};
      // node count lowered after loading
      rows = {rows, csr_row(CSR_NODE_COUNT, 7'd8)};
      rows = {rows, item_row(mk_item(6, 7, 1, 0))};
      rows = {rows, item_row(mk_item(0, 1, 1, 0))};
      rows = {rows, item_row(mk_item(1, 2, 1, 0))};
      rows = {rows, csr_row(CSR_NODE_COUNT, 7'd3)};
      rows = {rows, item_row(mk_item(0, 0, 0, 1))};
      // zero counts clamp to one
      rows = {rows, csr_row(CSR_NODE_COUNT, 7'd0)};
      rows = {rows, csr_row(CSR_REPORT_COUNT, 7'd0)};
      rows = {rows, item_row(mk_item(63, 63, 1, 0))};
      rows = {rows, known_row(mk_item(0, 0, 1, 1), mk_rsp(0, 1, 1, 1))};
      // oversized counts clamp to the node limit
      rows = {rows, csr_row(CSR_NODE_COUNT, 7'd127)};
      rows = {rows, csr_row(CSR_REPORT_COUNT, 7'd127)};
      rows = {rows, item_row(mk_item(63, 0, 1, 0))};
      rows = {rows, item_row(mk_item(62, 63, 1, 1))};

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            write_csr(rows[i].index, rows[i].wdata);
         end else begin
            qpos = ranked_q.size();
            send_item(rows[i].item);
            if (rows[i].known &&
                (ranked_q.size() <= qpos || ranked_q[qpos] != rows[i].known_rsp)) begin
               table_errors++;
               if (table_errors + mismatches <= 10)
                  $display("predictor disagrees with table row %0d", i);
            end
         end
      end

      // store full: more edges than capacity on a small graph
      write_csr(CSR_NODE_COUNT, 7'd8);
      write_csr(CSR_REPORT_COUNT, 7'd3);
      for (int i = 0; i < MAX_EDGES + 2; i++)
         send_item(mk_item($urandom_range(0, 7), $urandom_range(0, 7), 1,
                           i == MAX_EDGES + 1));

      // random graphs, idling dropped for the final stretch
      sent_at_start = items_sent;
      while (items_sent - sent_at_start < RANDOM_ITEMS) begin
         if (items_sent - sent_at_start > RANDOM_ITEMS * 85 / 100) idling_on = 1'b0;
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0: write_csr(CSR_NODE_COUNT, 7'($urandom_range(0, 127)));
               1: write_csr(CSR_NODE_COUNT, 7'd64);
               default: write_csr(CSR_NODE_COUNT, 7'($urandom_range(1, 16)));
            endcase
            write_csr(CSR_REPORT_COUNT, ($urandom_range(0, 4) == 0) ?
                      7'($urandom_range(0, 127)) : 7'($urandom_range(1, 6)));
         end
         n = (node_limit == 0) ? 1 : (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
         n_edges = $urandom_range(0, 14);
         for (int unsigned k = 0; k <= n_edges; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               a = $urandom_range(0, 63);
               b = $urandom_range(0, 63);
            end else begin
               a = $urandom_range(0, n - 1);
               b = $urandom_range(0, n - 1);
            end
            if (k == n_edges) it = mk_item(a, b, $urandom_range(0, 1), 1);
            else it = mk_item(a, b, ($urandom_range(0, 7) != 0), 0);
            send_item(it);
         end
      end
      start <= 1'b0;

      // drain
      while (ranked_q.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items over %0d graph runs, %0d ranked results checked",
               items_sent, runs_done, results_seen);
      $display("including clamped counts, dropped edges, full store and lowered node count");
      if (mismatches == 0 && table_errors == 0) begin
         $display("tb_cut_vertex_component_ranker: PASS");
      end else begin
         $display("%0d mismatches", mismatches + table_errors);
         $display("tb_cut_vertex_component_ranker: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/cvr_pkg.sv
design/cvr_front.sv
design/cvr_queue.sv
design/cvr_back.sv
design/cut_vertex_component_ranker.sv
tb/sv/tb_cut_vertex_component_ranker.sv
